FILE: design/euler_to_basis_vectors_top_defines.svh
// assertion macros shared by the checker
`ifndef EULER_TO_BASIS_VECTORS_TOP_DEFINES_SVH
`define EULER_TO_BASIS_VECTORS_TOP_DEFINES_SVH

// antecedent implies consequent on the next clock
`define E2B_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition holds at every clock
`define E2B_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

FILE: design/e2b_pkg.sv
// shared constants, types and tables for the euler to basis block
package e2b_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int STAGES_USED   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int TURN_UNITS    = 23040;
    localparam int QUARTER_UNITS = 5760;
    localparam int CORDIC_GAIN   = 652032874;
    localparam int Q14_MAX       = 16384;

    // trig values in q2.30, 33 bits wide
    typedef logic signed [32:0] trig_t;
    // cordic datapath width
    typedef logic signed [35:0] cw_t;
    // product of two trig values
    typedef logic signed [65:0] prod_t;

    typedef struct packed {
        trig_t sin_v;
        trig_t cos_v;
    } sc_t;

    function automatic logic signed [33:0] atan_entry(input int idx);
        logic signed [33:0] t;
        begin
            case (idx)
                0: t = 34'sd536870912;
                1: t = 34'sd316933406;
                2: t = 34'sd167458907;
                3: t = 34'sd85004756;
                4: t = 34'sd42667331;
                5: t = 34'sd21354465;
                6: t = 34'sd10679838;
                7: t = 34'sd5340245;
                8: t = 34'sd2670163;
                9: t = 34'sd1335087;
                10: t = 34'sd667544;
                11: t = 34'sd333772;
                12: t = 34'sd166886;
                13: t = 34'sd83443;
                14: t = 34'sd41722;
                15: t = 34'sd20861;
                16: t = 34'sd10430;
                17: t = 34'sd5215;
                18: t = 34'sd2608;
                19: t = 34'sd1304;
                20: t = 34'sd652;
                21: t = 34'sd326;
                22: t = 34'sd163;
                23: t = 34'sd81;
                default: t = 34'sd0;
            endcase
            return t;
        end
    endfunction

    // rounded q30 product
    function automatic trig_t mulq(input trig_t a, input trig_t b);
        prod_t p;
        begin
            p = prod_t'(a) * prod_t'(b) + (prod_t'(1) <<< 29);
            return trig_t'(p >>> 30);
        end
    endfunction

    function automatic logic [15:0] to_q14(input logic signed [34:0] v);
        logic signed [34:0] w;
        begin
            w = (v + 35'sd32768) >>> 16;
            if (w > 35'sd16384)
                w = 35'sd16384;
            if (w < -35'sd16384)
                w = -35'sd16384;
            return w[15:0];
        end
    endfunction

endpackage

FILE: design/e2b_cordic.sv
// pipelined sin/cos: angle reduce, cordic stages, quadrant fixup
module e2b_cordic (
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  ang,
    output e2b_pkg::sc_t        sc
);

    localparam int N = e2b_pkg::STAGES_USED;

    logic [14:0]        r_next;
    logic [14:0]        r_reg;
    logic [1:0]         q_reg;
    logic [12:0]        rem_reg;
    logic signed [33:0] z0_next;

    e2b_pkg::cw_t       x_reg [0:N];
    e2b_pkg::cw_t       y_reg [0:N];
    logic signed [33:0] z_reg [0:N];
    logic [1:0]         qq_reg [0:N];

    // ang + 46080 mod 23040, input spans -32768..32767
    always_comb
    begin
        logic signed [17:0] a;
        a = 18'(ang) + 18'sd46080;
        if (a >= 18'sd69120)
            a = a - 18'sd69120;
        else if (a >= 18'sd46080)
            a = a - 18'sd46080;
        else if (a >= 18'sd23040)
            a = a - 18'sd23040;
        r_next = a[14:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
        end
    end

    // quadrant split
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r_reg >= 15'd17280)
            begin
                q_reg <= 2'd3;
                rem_reg <= 13'(r_reg - 15'd17280);
            end
            else if (r_reg >= 15'd11520)
            begin
                q_reg <= 2'd2;
                rem_reg <= 13'(r_reg - 15'd11520);
            end
            else if (r_reg >= 15'd5760)
            begin
                q_reg <= 2'd1;
                rem_reg <= 13'(r_reg - 15'd5760);
            end
            else
            begin
                q_reg <= 2'd0;
                rem_reg <= 13'(r_reg);
            end
        end
    end

    // (rem*2^26+180)/360 = (rem*2^23+22)/45 with 2^23 = 45*186413 + 23,
    // so the quotient is rem*186413 + (23*rem+22)/45; the small division
    // uses the reciprocal 186414/2^23, exact for operands below 2^18
    always_comb
    begin
        logic [30:0] hi;
        logic [17:0] t;
        logic [35:0] lo_prod;
        hi      = 31'(rem_reg) * 31'd186413;
        t       = 18'(rem_reg) * 18'd23 + 18'd22;
        lo_prod = 36'(t) * 36'd186414;
        z0_next = 34'(hi) + 34'(lo_prod >> 23);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= e2b_pkg::cw_t'(e2b_pkg::CORDIC_GAIN);
            y_reg[0]  <= '0;
            z_reg[0]  <= z0_next;
            qq_reg[0] <= q_reg;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - e2b_pkg::atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + e2b_pkg::atan_entry(i);
                end
                qq_reg[i+1] <= qq_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (qq_reg[N])
                2'd0:
                begin
                    sc.sin_v <= e2b_pkg::trig_t'(y_reg[N]);
                    sc.cos_v <= e2b_pkg::trig_t'(x_reg[N]);
                end
                2'd1:
                begin
                    sc.sin_v <= e2b_pkg::trig_t'(x_reg[N]);
                    sc.cos_v <= e2b_pkg::trig_t'(-y_reg[N]);
                end
                2'd2:
                begin
                    sc.sin_v <= e2b_pkg::trig_t'(-y_reg[N]);
                    sc.cos_v <= e2b_pkg::trig_t'(-x_reg[N]);
                end
                default:
                begin
                    sc.sin_v <= e2b_pkg::trig_t'(-x_reg[N]);
                    sc.cos_v <= e2b_pkg::trig_t'(y_reg[N]);
                end
            endcase
        end
    end

endmodule

FILE: design/e2b_matrix.sv
// pitch/yaw and roll product stages, then sums and rounding that form the nine components
module e2b_matrix (
    input  logic          clk,
    input  logic          en,
    input  e2b_pkg::sc_t  p,
    input  e2b_pkg::sc_t  y,
    input  e2b_pkg::sc_t  r,
    input  logic          tr,
    output logic [143:0]  comp
);

    e2b_pkg::trig_t spcy_reg, spsy_reg, cpcy_reg, cpsy_reg, sp1_reg, cp1_reg;
    e2b_pkg::trig_t sr1_reg, cr1_reg, sy1_reg, cy1_reg;
    logic           tr1_reg, tr2_reg;
    e2b_pkg::trig_t m_reg [0:12];
    logic signed [34:0] v [0:8];

    // stage one: pitch/yaw products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spcy_reg <= e2b_pkg::mulq(p.sin_v, y.cos_v);
            spsy_reg <= e2b_pkg::mulq(p.sin_v, y.sin_v);
            cpcy_reg <= e2b_pkg::mulq(p.cos_v, y.cos_v);
            cpsy_reg <= e2b_pkg::mulq(p.cos_v, y.sin_v);
            sp1_reg  <= p.sin_v;
            cp1_reg  <= p.cos_v;
            sr1_reg  <= r.sin_v;
            cr1_reg  <= r.cos_v;
            sy1_reg  <= y.sin_v;
            cy1_reg  <= y.cos_v;
            tr1_reg  <= tr;
        end
    end

    // stage two: roll products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]  <= cpcy_reg;
            m_reg[1]  <= cpsy_reg;
            m_reg[2]  <= sp1_reg;
            m_reg[3]  <= e2b_pkg::mulq(sr1_reg, spcy_reg);
            m_reg[4]  <= e2b_pkg::mulq(cr1_reg, sy1_reg);
            m_reg[5]  <= e2b_pkg::mulq(sr1_reg, spsy_reg);
            m_reg[6]  <= e2b_pkg::mulq(cr1_reg, cy1_reg);
            m_reg[7]  <= e2b_pkg::mulq(sr1_reg, cp1_reg);
            m_reg[8]  <= e2b_pkg::mulq(cr1_reg, spcy_reg);
            m_reg[9]  <= e2b_pkg::mulq(sr1_reg, sy1_reg);
            m_reg[10] <= e2b_pkg::mulq(cr1_reg, spsy_reg);
            m_reg[11] <= e2b_pkg::mulq(sr1_reg, cy1_reg);
            m_reg[12] <= e2b_pkg::mulq(cr1_reg, cp1_reg);
            tr2_reg   <= tr1_reg;
        end
    end

    // stage three: sums, signs, rounding
    always_comb
    begin
        logic signed [34:0] a3, a4, a5, a6, a7;
        a3 = 35'(m_reg[3]) - 35'(m_reg[4]);
        a4 = 35'(m_reg[5]) + 35'(m_reg[6]);
        a6 = 35'(m_reg[8]) + 35'(m_reg[9]);
        a7 = 35'(m_reg[10]) - 35'(m_reg[11]);
        a5 = 35'(m_reg[7]);
        if (!tr2_reg)
        begin
            v[0] = 35'(m_reg[0]);
            v[1] = 35'(m_reg[1]);
            v[2] = -35'(m_reg[2]);
            v[3] = -a3;
            v[4] = -a4;
            v[5] = -a5;
            v[6] = a6;
            v[7] = a7;
            v[8] = 35'(m_reg[12]);
        end
        else
        begin
            v[0] = 35'(m_reg[0]);
            v[1] = a3;
            v[2] = a6;
            v[3] = 35'(m_reg[1]);
            v[4] = a4;
            v[5] = a7;
            v[6] = -35'(m_reg[2]);
            v[7] = a5;
            v[8] = 35'(m_reg[12]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                comp[k*16 +: 16] <= e2b_pkg::to_q14(v[k]);
            end
        end
    end

endmodule

FILE: design/euler_to_basis_vectors_top.sv
// top level of the euler angle to basis vector pipeline
//
// usage:
//   s_axis carries one word per angle set: tdata holds pitch, yaw, roll
//   (16-bit signed, 1/64 degree each); tuser holds the transposed flag.
//   m_axis gives one word per input word: nine q1.14 components packed in
//   tdata, vec0_x in the lowest bits up to vec2_z.
//   from input accept to output, a word passes the reduction registers
//   (range, then quadrant split), the angle conversion register, the cordic
//   stages (16 here), a quadrant fixup register and the product and rounding
//   registers, the last of which drives m_axis directly.
//   throughput: one word per cycle unless stalled; the pipe moves as one.
//   when the receiver stalls, the whole pipe freezes and s_axis_tready drops
//   for as long as the output holds an untaken word; bubbles inside the
//   pipe are not squeezed out.
//   reset clears all valid bits; data registers are not reset.
module euler_to_basis_vectors_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // pitch, yaw, roll
    input  logic         s_axis_tuser,   // transposed
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // vec0_x..z, vec1_x..z, vec2_x..z
);

    localparam int LAT = e2b_pkg::STAGES_USED + 7;

    logic         en;
    logic [LAT-2:0] vld_reg;
    logic [LAT-4:0] tr_reg;
    logic           out_vld_reg;
    e2b_pkg::sc_t   sc_p, sc_y, sc_r;
    logic [143:0]   comp;

    // simple global stall: whole pipe moves when output can take a word
    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = comp;

    // out_vld_reg lines up with the final component register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[LAT-3:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[LAT-2];
        end
    end

    // transposed flag rides along until the matrix stage needs it
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_reg <= {tr_reg[LAT-5:0], s_axis_tuser};
        end
    end

    e2b_cordic u_cord_p (.clk(clk), .en(en),
                         .ang(s_axis_tdata[15:0]), .sc(sc_p));
    e2b_cordic u_cord_y (.clk(clk), .en(en),
                         .ang(s_axis_tdata[31:16]), .sc(sc_y));
    e2b_cordic u_cord_r (.clk(clk), .en(en),
                         .ang(s_axis_tdata[47:32]), .sc(sc_r));

    e2b_matrix u_matrix (
        .clk  (clk),
        .en   (en),
        .p    (sc_p),
        .y    (sc_y),
        .r    (sc_r),
        .tr   (tr_reg[LAT-4]),
        .comp (comp)
    );

endmodule

FILE: design/e2b_checker.sv
// port-level checks of the euler to basis pipeline
`include "euler_to_basis_vectors_top_defines.svh"

module e2b_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);

    `E2B_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `E2B_ASSERT_NEXT(a_hold_data, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `E2B_ASSERT_ALWAYS(a_ready_free, clk, rst_n, m_axis_tvalid || s_axis_tready)
    `E2B_ASSERT_ALWAYS(a_stall_ready, clk, rst_n, !(m_axis_tvalid && !m_axis_tready && s_axis_tready))

endmodule

bind euler_to_basis_vectors_top e2b_checker u_e2b_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
